[hw/rtl/i2cmrr_pkg.sv]
// Shared types and constants for the I2C combined register read master.
package i2cmrr_pkg;

  localparam int unsigned TIMER_BITS_DEFAULT = 16;
  localparam int unsigned CFG_DATA_W         = 16;

  localparam logic [6:0]  DEV_ADDR_RESET    = 7'd85;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
  localparam logic [15:0] STRETCH_RESET     = 16'd100;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR    = 2'd0,
    CFG_PHASE_TICKS = 2'd1,
    CFG_STRETCH     = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE      = 5'd0,
    S_START     = 5'd1,
    S_ADDR_W    = 5'd2,
    S_CMD       = 5'd3,
    S_RESTART   = 5'd4,
    S_ADDR_R    = 5'd5,
    S_READ      = 5'd6,
    S_STOP_OK   = 5'd7,
    S_STOP_FAIL = 5'd8
  } seq_state_e;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
    logic [15:0] stretch_timeout;
  } cfg_t;

  typedef struct packed {
    logic        scl_pull_low;
    logic        sda_pull_low;
    logic        busy;
    logic        done;
    logic        success;
    logic [15:0] read_value;
  } res_t;

endpackage

[hw/rtl/i2cmrr_seq.sv]
// Bus sequencer: one tick per beat, phase timing, byte shifting and line drive.
module i2cmrr_seq #(
  parameter int unsigned TIMER_BITS = i2cmrr_pkg::TIMER_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  i2cmrr_pkg::cfg_t  cfg_i,
  input  logic              start_request_i,
  input  logic [7:0]        register_command_i,
  input  logic [1:0]        read_length_i,
  input  logic              sda_level_i,
  input  logic              scl_level_i,
  output i2cmrr_pkg::res_t  res_o
);
  import i2cmrr_pkg::*;

  localparam int unsigned CW = (TIMER_BITS + 1 > 16) ? TIMER_BITS + 1 : 16;
  localparam logic [CW-1:0] TMASK    = CW'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [CW-1:0] PLEN_MAX = CW'(64'd1 << TIMER_BITS);

  seq_state_e            state_q, state_d;
  logic [3:0]            bc_q, bc_d;
  logic [1:0]            phase_q, phase_d;
  logic [TIMER_BITS-1:0] ptimer_q, ptimer_d;
  logic [TIMER_BITS-1:0] stimer_q, stimer_d;
  logic [7:0]            shift_q, shift_d;
  logic [15:0]           word_q, word_d;
  logic                  bidx_q, bidx_d;
  logic [7:0]            cmd_q, cmd_d;
  logic                  len2_q, len2_d;

  logic [CW-1:0] plen, slim, pt_next;
  logic          waits, is_send, more, ok, done;
  logic [15:0]   value;

  always_comb begin
    is_send = (state_q == S_ADDR_W) || (state_q == S_CMD) || (state_q == S_ADDR_R);
    more    = !bidx_q && len2_q;
    if (is_send || state_q == S_READ) begin
      waits = (phase_q == 2'd2);
    end else if (state_q == S_RESTART || state_q == S_STOP_OK ||
                 state_q == S_STOP_FAIL) begin
      waits = (phase_q == 2'd1);
    end else begin
      waits = 1'b0;
    end
    plen = (cfg_i.phase_ticks == 16'd0) ? CW'(1) : CW'(cfg_i.phase_ticks);
    if (plen > PLEN_MAX) plen = PLEN_MAX;
    slim = CW'(cfg_i.stretch_timeout);
    if (slim > TMASK) slim = TMASK;
    pt_next = CW'(ptimer_q) + CW'(1);
  end

  always_comb begin
    state_d  = state_q;
    bc_d     = bc_q;
    phase_d  = phase_q;
    ptimer_d = ptimer_q;
    stimer_d = stimer_q;
    shift_d  = shift_q;
    word_d   = word_q;
    bidx_d   = bidx_q;
    cmd_d    = cmd_q;
    len2_d   = len2_q;
    ok       = 1'b0;
    done     = 1'b0;
    value    = 16'd0;
    if (state_q == S_IDLE) begin
      if (start_request_i) begin
        cmd_d    = register_command_i;
        len2_d   = read_length_i[1];
        state_d  = S_START;
        bc_d     = 4'd0;
        phase_d  = 2'd0;
        ptimer_d = '0;
        stimer_d = '0;
        bidx_d   = 1'b0;
        word_d   = 16'd0;
        shift_d  = 8'd0;
      end
    end else if (ptimer_q == '0 && waits && !scl_level_i && CW'(stimer_q) < slim) begin
      stimer_d = stimer_q + TIMER_BITS'(1);
    end else if (pt_next >= plen) begin
      ptimer_d = '0;
      stimer_d = '0;
      if (phase_q == 2'd3) begin
        phase_d = 2'd0;
        case (state_q)
          S_START: begin
            state_d = S_ADDR_W;
            shift_d = {cfg_i.device_address, 1'b0};
            bc_d    = 4'd0;
          end
          S_ADDR_W, S_CMD, S_ADDR_R: begin
            if (bc_q < 4'd8) begin
              shift_d = {shift_q[6:0], 1'b0};
              bc_d    = bc_q + 4'd1;
            end else begin
              bc_d = 4'd0;
              if (sda_level_i) begin
                state_d = S_STOP_FAIL;
              end else if (state_q == S_ADDR_W) begin
                state_d = S_CMD;
                shift_d = cmd_q;
              end else if (state_q == S_CMD) begin
                state_d = S_RESTART;
              end else begin
                state_d = S_READ;
                shift_d = 8'd0;
                bidx_d  = 1'b0;
                word_d  = 16'd0;
              end
            end
          end
          S_READ: begin
            if (bc_q < 4'd8) begin
              shift_d = {shift_q[6:0], sda_level_i};
              bc_d    = bc_q + 4'd1;
            end else begin
              word_d  = bidx_q ? {shift_q, word_q[7:0]} : {8'd0, shift_q};
              bc_d    = 4'd0;
              shift_d = 8'd0;
              if (more) bidx_d = 1'b1;
              else state_d = S_STOP_OK;
            end
          end
          S_RESTART: begin
            state_d = S_ADDR_R;
            shift_d = {cfg_i.device_address, 1'b1};
            bc_d    = 4'd0;
          end
          S_STOP_OK, S_STOP_FAIL: begin
            ok      = (state_q == S_STOP_OK);
            value   = (state_q == S_STOP_OK) ? word_q : 16'd0;
            state_d = S_IDLE;
            bc_d    = 4'd0;
            done    = 1'b1;
          end
          default: ;
        endcase
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end else begin
      ptimer_d = ptimer_q + TIMER_BITS'(1);
    end
  end

  // line drive after this tick
  always_comb begin
    res_o              = '0;
    res_o.busy         = (state_d != S_IDLE);
    res_o.done         = done;
    res_o.success      = ok;
    res_o.read_value   = value;
    case (state_d)
      S_START: begin
        res_o.sda_pull_low = (phase_d >= 2'd1);
        res_o.scl_pull_low = (phase_d >= 2'd2);
      end
      S_ADDR_W, S_CMD, S_ADDR_R: begin
        res_o.scl_pull_low = (phase_d < 2'd2);
        res_o.sda_pull_low = (bc_d < 4'd8) && !shift_d[7];
      end
      S_READ: begin
        res_o.scl_pull_low = (phase_d < 2'd2);
        res_o.sda_pull_low = (bc_d >= 4'd8) && !bidx_d && len2_d;
      end
      S_RESTART: begin
        res_o.scl_pull_low = (phase_d == 2'd0) || (phase_d == 2'd3);
        res_o.sda_pull_low = (phase_d >= 2'd2);
      end
      S_STOP_OK, S_STOP_FAIL: begin
        res_o.scl_pull_low = (phase_d == 2'd0);
        res_o.sda_pull_low = (phase_d <= 2'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bc_q     <= 4'd0;
      phase_q  <= 2'd0;
      ptimer_q <= '0;
      stimer_q <= '0;
      shift_q  <= 8'd0;
      word_q   <= 16'd0;
      bidx_q   <= 1'b0;
      cmd_q    <= 8'd0;
      len2_q   <= 1'b0;
    end else if (tick_i) begin
      state_q  <= state_d;
      bc_q     <= bc_d;
      phase_q  <= phase_d;
      ptimer_q <= ptimer_d;
      stimer_q <= stimer_d;
      shift_q  <= shift_d;
      word_q   <= word_d;
      bidx_q   <= bidx_d;
      cmd_q    <= cmd_d;
      len2_q   <= len2_d;
    end
  end

endmodule

[hw/rtl/i2c_master_register_read.sv]
// Top level of the I2C combined register read master.
// The result of an accepted tick beat is registered and appears as its result beat in the cycle after it.
// Throughput: one beat per cycle unless stalled; the sequencer steps once per accepted beat.
// The input stalls only while the output register holds a beat that is stalled.
// Reset clears the sequencer to idle and loads the register defaults.
module i2c_master_register_read #(
  parameter int unsigned TIMER_BITS = i2cmrr_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [i2cmrr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              start_request_i,
  input  logic [7:0]                        register_command_i,
  input  logic [1:0]                        read_length_i,
  input  logic                              sda_level_i,
  input  logic                              scl_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              scl_pull_low_o,
  output logic                              sda_pull_low_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic                              success_o,
  output logic [15:0]                       read_value_o
);
  import i2cmrr_pkg::*;

  cfg_t cfg_q;
  res_t res, res_q;
  logic out_valid_q, accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address  <= DEV_ADDR_RESET;
      cfg_q.phase_ticks     <= PHASE_TICKS_RESET;
      cfg_q.stretch_timeout <= STRETCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEV_ADDR:    cfg_q.device_address  <= cfg_data_i[6:0];
        CFG_PHASE_TICKS: cfg_q.phase_ticks     <= cfg_data_i[15:0];
        CFG_STRETCH:     cfg_q.stretch_timeout <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  i2cmrr_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tick_i             (accept),
    .cfg_i              (cfg_q),
    .start_request_i    (start_request_i),
    .register_command_i (register_command_i),
    .read_length_i      (read_length_i),
    .sda_level_i        (sda_level_i),
    .scl_level_i        (scl_level_i),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_pull_low_o = res_q.scl_pull_low;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;
  assign success_o      = res_q.success;
  assign read_value_o   = res_q.read_value;

`ifndef SYNTHESIS
  a_success_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.success) |-> res_q.done)
    else $error("success without done");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done) |-> !res_q.busy)
    else $error("done while still busy");
  a_fail_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.success) |-> (res_q.read_value == 16'd0))
    else $error("read value nonzero without success");
  a_stalled_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result beat changed");
`endif

endmodule
